[rtl/block_bitmap_allocator_core_defines.svh]
// Assertion macros for the block bitmap allocator.
// Included by the top level only; relies on signals named clk and rst_n.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba: next-cycle check failed");

`endif

[rtl/bba_pkg.sv]
// Shared types and constants of the block bitmap allocator.
// No dependencies; used by the top level only.
`default_nettype none

package bba_pkg;

    // Fixed port widths
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W     = 3;
    localparam int BLK_W    = 12;
    localparam int STATUS_W = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_MARK_USED = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST      = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] FIRST_DATA_BLOCK_RST = 13'd0;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                bit_is_set;
        logic [BLK_W-1:0]    free_block;
    } res_t;

endpackage

`default_nettype wire

[rtl/bba_span_mask.sv]
// Bit mask of the positions of one map word whose block number lies below a bound.
// Standalone; used by the scan unit and by the init/clear sweep.
`default_nettype none

module bba_span_mask #(
    parameter int WORD_BITS = 32,
    parameter int CW        = 13
) (
    input  logic [CW-1:0]        base,
    input  logic [CW-1:0]        bound,
    output logic [WORD_BITS-1:0] mask
);

    localparam int SW = $clog2(WORD_BITS);

    logic [CW-1:0] diff;

    assign diff = bound - base;

    // Bit j is set when base + j < bound
    always_comb
    begin
        if (bound <= base)
        begin
            mask = '0;
        end
        else if (diff >= CW'(WORD_BITS))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({WORD_BITS{1'b1}} << diff[SW-1:0]);
        end
    end

endmodule

`default_nettype wire

[rtl/bba_scan.sv]
// Free-bit search over one map word, limited to [first data block, limit).
// Depends on bba_span_mask.
`default_nettype none

module bba_scan #(
    parameter int WORD_BITS = 32,
    parameter int CW        = 13
) (
    input  logic [WORD_BITS-1:0]         word,
    input  logic [CW-1:0]                base,
    input  logic [CW-1:0]                lo_bound,
    input  logic [CW-1:0]                hi_bound,
    output logic                         hit,
    output logic [$clog2(WORD_BITS)-1:0] hit_pos
);

    localparam int SW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] below_lo;
    logic [WORD_BITS-1:0] below_hi;
    logic [WORD_BITS-1:0] avail;

    bba_span_mask #(.WORD_BITS(WORD_BITS), .CW(CW)) u_lo_mask (
        .base  (base),
        .bound (lo_bound),
        .mask  (below_lo)
    );

    bba_span_mask #(.WORD_BITS(WORD_BITS), .CW(CW)) u_hi_mask (
        .base  (base),
        .bound (hi_bound),
        .mask  (below_hi)
    );

    // Free, not reserved, and inside the valid range
    assign avail = ~word & ~below_lo & below_hi;
    assign hit   = |avail;

    // Lowest set position wins
    always_comb
    begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                hit_pos = SW'(j);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bba_map_ram.sv]
// Used-block map storage: one write port and one registered read port.
// Standalone; a read of the address written in the same cycle returns the new word.
`default_nettype none

module bba_map_ram #(
    parameter int WORD_BITS = 32,
    parameter int DEPTH     = 128,
    parameter int AW        = 7
) (
    input  logic                 clk,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with write-first forwarding; data holds when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/block_bitmap_allocator_core.sv]
// Block bitmap allocator top level: control, config registers, result register.
// Depends on bba_pkg, bba_map_ram, bba_scan, bba_span_mask and the defines header.
//
// One bit per storage block (1 = used) held in a single memory of
// CAPACITY/WORD_BITS words with a registered read. Mark used, mark free and test
// are a read-modify-write: the word is read when the item is taken; once the data
// is back a mark writes the modified word, the result is posted and the next item is
// taken in that same cycle, so these run at one item per cycle while out_ready does
// not hold the result. Find reads one map word per cycle starting at the word that
// holds first_data_block. Init writes every map word, one per cycle. After reset the
// same sweep clears the memory with in_ready low; config writes are taken at any time.
// The single memory port pair sets the pace of all of these.
`default_nettype none
`include "block_bitmap_allocator_core_defines.svh"

module block_bitmap_allocator_core #(
    parameter int CAPACITY  = 4096,
    parameter int WORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bba_pkg::OP_W-1:0]        opcode,
    input  logic [bba_pkg::BLK_W-1:0]       block_number,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bba_pkg::STATUS_W-1:0]    status,
    output logic                            bit_is_set,
    output logic [bba_pkg::BLK_W-1:0]       free_block
);

    localparam int SW        = $clog2(WORD_BITS);
    localparam int MAP_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int XW        = AW + SW;
    localparam int LW        = $clog2(CAPACITY + 1);
    localparam int CW0       = (LW > bba_pkg::CFG_W) ? LW : bba_pkg::CFG_W;
    localparam int CW        = (XW + 1 > CW0) ? XW + 1 : CW0;

    // State codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RMW   = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    // Config registers
    logic [bba_pkg::CFG_W-1:0] blocks_in_use_reg;
    logic [bba_pkg::CFG_W-1:0] first_data_block_reg;

    // Control and item registers
    logic [1:0]                 state_reg, state_next;
    logic [bba_pkg::OP_W-1:0]   op_reg, op_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [SW-1:0]              bit_reg, bit_next;
    logic                       err_reg, err_next;
    logic [AW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic                       rd_done_reg, rd_done_next;
    logic                       chk_valid_reg, chk_valid_next;
    logic [AW-1:0]              chk_ptr_reg, chk_ptr_next;
    logic                       empty_reg, empty_next;
    logic [AW-1:0]              sweep_ptr_reg, sweep_ptr_next;
    logic                       report_reg, report_next;
    logic                       out_valid_reg, out_valid_next;
    bba_pkg::res_t              out_reg, out_next;

    // Datapath signals
    logic [CW-1:0]              cap_c;
    logic [CW-1:0]              biu_ext;
    logic [CW-1:0]              fdb_ext;
    logic [CW-1:0]              lim;
    logic [CW-1:0]              lim_m1;
    logic [CW-1:0]              blk_ext;
    logic [CW-1:0]              init_bound;
    logic [CW-1:0]              sweep_bound;
    logic [CW-1:0]              chk_base;
    logic [CW-1:0]              sweep_base;
    logic [AW-1:0]              find_start;
    logic [AW-1:0]              find_last;
    logic [AW-1:0]              in_addr;
    logic                       out_free;
    logic                       accept;
    logic                       out_load;
    bba_pkg::res_t              res;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [WORD_BITS-1:0]       mem_rdata;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [WORD_BITS-1:0]       mem_wdata;
    logic [WORD_BITS-1:0]       rmw_word;
    logic [WORD_BITS-1:0]       sweep_word;
    logic                       scan_hit;
    logic [SW-1:0]              scan_pos;
    logic                       chk_last;
    logic                       find_done;
    logic                       sweep_last;
    logic                       is_find;
    logic                       is_init;

    // Effective limits from the config registers
    assign cap_c       = CW'(CAPACITY);
    assign biu_ext     = CW'(blocks_in_use_reg);
    assign fdb_ext     = CW'(first_data_block_reg);
    assign lim         = (biu_ext > cap_c) ? cap_c : biu_ext;
    assign lim_m1      = lim - CW'(1);
    assign init_bound  = (fdb_ext < lim) ? fdb_ext : lim;
    assign sweep_bound = report_reg ? init_bound : '0;
    assign find_start  = fdb_ext[XW-1:SW];
    assign find_last   = lim_m1[XW-1:SW];

    // Input block split into word address and bit position
    assign blk_ext = CW'(block_number);
    assign in_addr = blk_ext[XW-1:SW];

    assign chk_base   = CW'({chk_ptr_reg, {SW{1'b0}}});
    assign sweep_base = CW'({sweep_ptr_reg, {SW{1'b0}}});
    assign chk_last   = (chk_ptr_reg == find_last);
    assign sweep_last = (sweep_ptr_reg == AW'(MAP_WORDS - 1));
    assign find_done  = empty_reg || (chk_valid_reg && (scan_hit || chk_last));

    assign is_find = (opcode == bba_pkg::OP_FIND);
    assign is_init = (opcode == bba_pkg::OP_INIT);

    // Handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_RMW) && out_free);
    assign accept   = in_valid && in_ready;

    // Modified word for mark used / mark free
    always_comb
    begin
        rmw_word          = mem_rdata;
        rmw_word[bit_reg] = (op_reg == bba_pkg::OP_MARK_USED);
    end

    bba_map_ram #(.WORD_BITS(WORD_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_map_ram (
        .clk   (clk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    bba_scan #(.WORD_BITS(WORD_BITS), .CW(CW)) u_scan (
        .word     (mem_rdata),
        .base     (chk_base),
        .lo_bound (fdb_ext),
        .hi_bound (lim),
        .hit      (scan_hit),
        .hit_pos  (scan_pos)
    );

    bba_span_mask #(.WORD_BITS(WORD_BITS), .CW(CW)) u_sweep_mask (
        .base  (sweep_base),
        .bound (sweep_bound),
        .mask  (sweep_word)
    );

    // Next-state and memory control
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        err_next       = err_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_done_next   = rd_done_reg;
        chk_valid_next = chk_valid_reg;
        chk_ptr_next   = chk_ptr_reg;
        empty_next     = empty_reg;
        sweep_ptr_next = sweep_ptr_reg;
        report_next    = report_reg;
        mem_re         = 1'b0;
        mem_raddr      = in_addr;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = rmw_word;
        out_load       = 1'b0;
        res            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
            end

            // Read data is back: write the modified word for a valid mark and post the result
            S_RMW:
            begin
                res.status     = err_reg ? bba_pkg::ST_RANGE : bba_pkg::ST_DONE;
                res.bit_is_set = (op_reg == bba_pkg::OP_TEST) && !err_reg
                                 && mem_rdata[bit_reg];
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mem_we     = !err_reg && ((op_reg == bba_pkg::OP_MARK_USED)
                                 || (op_reg == bba_pkg::OP_MARK_FREE));
                    state_next = S_IDLE;
                end
            end

            // One word read per cycle, checked the cycle after
            S_FIND:
            begin
                mem_raddr = rd_ptr_reg;
                if (!empty_reg && scan_hit)
                begin
                    res.status     = bba_pkg::ST_DONE;
                    res.free_block = bba_pkg::BLK_W'({chk_ptr_reg, scan_pos});
                end
                else
                begin
                    res.status = bba_pkg::ST_NOFREE;
                end
                if (find_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_re         = !rd_done_reg;
                    chk_valid_next = !rd_done_reg;
                    chk_ptr_next   = rd_ptr_reg;
                    if (!rd_done_reg)
                    begin
                        if (rd_ptr_reg == find_last)
                        begin
                            rd_done_next = 1'b1;
                        end
                        else
                        begin
                            rd_ptr_next = rd_ptr_reg + AW'(1);
                        end
                    end
                end
            end

            // Init or post-reset clear: one word written per cycle
            S_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_ptr_reg;
                mem_wdata  = sweep_word;
                res.status = bba_pkg::ST_DONE;
                if (!sweep_last)
                begin
                    sweep_ptr_next = sweep_ptr_reg + AW'(1);
                end
                else if (!report_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase

        // New item
        if (accept)
        begin
            op_next = opcode;
            if (is_find)
            begin
                state_next     = S_FIND;
                rd_ptr_next    = find_start;
                rd_done_next   = 1'b0;
                chk_valid_next = 1'b0;
                empty_next     = (fdb_ext >= lim);
            end
            else if (is_init)
            begin
                state_next     = S_SWEEP;
                sweep_ptr_next = '0;
                report_next    = 1'b1;
            end
            else
            begin
                state_next = S_RMW;
                mem_re     = 1'b1;
                addr_next  = in_addr;
                bit_next   = blk_ext[SW-1:0];
                err_next   = (blk_ext >= lim) && ((opcode == bba_pkg::OP_MARK_USED)
                             || (opcode == bba_pkg::OP_MARK_FREE)
                             || (opcode == bba_pkg::OP_TEST));
            end
        end
    end

    // Result register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg    <= bba_pkg::BLOCKS_IN_USE_RST;
            first_data_block_reg <= bba_pkg::FIRST_DATA_BLOCK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bba_pkg::CFG_BLOCKS_IN_USE:    blocks_in_use_reg    <= cfg_data;
                bba_pkg::CFG_FIRST_DATA_BLOCK: first_data_block_reg <= cfg_data;
            endcase
        end
    end

    // Control registers; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            rd_ptr_reg    <= '0;
            rd_done_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
            empty_reg     <= 1'b0;
            sweep_ptr_reg <= '0;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_done_reg   <= rd_done_next;
            chk_valid_reg <= chk_valid_next;
            empty_reg     <= empty_next;
            sweep_ptr_reg <= sweep_ptr_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        bit_reg     <= bit_next;
        err_reg     <= err_next;
        chk_ptr_reg <= chk_ptr_next;
        out_reg     <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign bit_is_set = out_reg.bit_is_set;
    assign free_block = out_reg.free_block;

    // A waiting result is never overwritten
    `BBA_ASSERT_IMPL(a_no_result_overwrite, out_valid_reg && !out_ready, !out_load)
    // The find walk never reads past the last valid word
    `BBA_ASSERT_IMPL(a_find_read_bound, (state_reg == S_FIND) && mem_re, rd_ptr_reg <= find_last)
    // No item is taken during the post-reset clear
    `BBA_ASSERT_IMPL(a_clear_blocks_input, (state_reg == S_SWEEP) && !report_reg, !in_ready)
    // An accepted mark or test is served from its own read the next cycle
    `BBA_ASSERT_NEXT(a_rmw_follows, accept && !is_find && !is_init, state_reg == S_RMW)

endmodule

`default_nettype wire
